// File: sv/periodic_timer_slot_table_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the periodic timer slot table
// Concurrent checks with a synthesis-time empty form.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_SLOT_TABLE_MACROS_SVH
`define PERIODIC_TIMER_SLOT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/pts_pkg.sv
// ---------------------------------------------------------------------------
// Periodic timer slot table package
// Beat types, request and result codes, slot entry layout, sequencer states.
// ---------------------------------------------------------------------------
package pts_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLOSE = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        RES_SET     = 2'd0,
        RES_EXPIRED = 2'd1,
        RES_TICK    = 2'd2,
        RES_CLOSE   = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] timer_id;
        logic [31:0] reload_ticks;
        logic        notify_enable;
    } pts_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] expired_id;
        logic        set_ok;
        logic [31:0] system_time;
        logic        last;
    } pts_out_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] reload;
        logic [31:0] count;
        logic        notify;
    } slot_entry_t;

endpackage

// File: sv/pts_ram.sv
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/pts_out_stage.sv
// ---------------------------------------------------------------------------
// Result output register
// Holds one result beat until the receiver takes it.
// ---------------------------------------------------------------------------
module pts_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pts_pkg::pts_out_t beat,
    output logic              free,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pts_pkg::pts_out_t rsp_data
);
    import pts_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    pts_out_t data_reg;

    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= beat;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule

// File: sv/periodic_timer_slot_table.sv
// ---------------------------------------------------------------------------
// Periodic timer slot table
// Table of NUM_SLOTS periodic timers serving tick, set and close requests.
// ---------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready/req_data; results leave on
// rsp_valid/rsp_ready/rsp_data, one beat per result, with last marking
// the final beat of a request.
// Every known request walks all slots in index order, one slot per cycle when not stalled,
// through the single read port of the slot RAM (id, reload, count, notify);
// enable bits sit in flip-flops. After the walk, the final beat is loaded
// in the final state once the output register is free, and the block then
// returns to idle to take the next request.
// A tick emits one expiry beat per enabled slot with a zero count and
// notify set, then a tick-done beat carrying the system time.
// Set and close give a single beat. Request code 3 is dropped at once.
// Reset clears the enable bits and the system time; no clearing pass runs,
// so the block is ready as soon as reset is released.
// When the receiver stalls, the walk holds on any slot that needs to emit
// while the output register is still occupied.
// ---------------------------------------------------------------------------
`include "periodic_timer_slot_table_macros.svh"

module periodic_timer_slot_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pts_pkg::pts_in_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pts_pkg::pts_out_t rsp_data
);
    import pts_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENT_W = $bits(slot_entry_t);

    state_t                 state_reg;
    state_t                 state_next;
    pts_in_t                req_reg;
    pts_in_t                req_next;
    logic [IDX_W-1:0]       proc_idx_reg;
    logic [IDX_W-1:0]       proc_idx_next;
    logic [NUM_SLOTS-1:0]   enable_reg;
    logic [NUM_SLOTS-1:0]   enable_next;
    logic                   found_reg;
    logic                   found_next;
    logic [31:0]            tick_total_reg;
    logic [31:0]            tick_total_next;

    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;
    slot_entry_t            wentry;
    slot_entry_t            entry;

    logic                   out_load;
    logic                   out_free;
    pts_out_t               beat;

    logic                   req_fire;
    logic                   req_known;
    logic                   cur_en;
    logic                   need_emit;
    logic                   stall;
    logic                   last_slot;

    assign entry     = slot_entry_t'(ram_rdata);
    assign cur_en    = enable_reg[proc_idx_reg];
    assign need_emit = (req_reg.req_type == REQ_TICK) && cur_en
                       && (entry.count == 32'd0) && entry.notify;
    assign stall     = (state_reg == ST_SCAN) && need_emit && !out_free;
    assign last_slot = (proc_idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign req_known = (req_data.req_type == REQ_TICK) || (req_data.req_type == REQ_SET)
                       || (req_data.req_type == REQ_CLOSE);

    pts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (proc_idx_reg),
        .wdata (wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pts_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .beat      (beat),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req_known)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall && last_slot)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next        = req_reg;
        proc_idx_next   = proc_idx_reg;
        enable_next     = enable_reg;
        found_next      = found_reg;
        tick_total_next = tick_total_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        wentry          = entry;
        out_load        = 1'b0;
        beat            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req_known)
                begin
                    req_next      = req_data;
                    proc_idx_next = '0;
                    found_next    = 1'b0;
                    ram_re        = 1'b1;
                    if (req_data.req_type == REQ_TICK)
                    begin
                        tick_total_next = tick_total_reg + 32'd1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    case (req_reg.req_type)
                        REQ_TICK:
                        begin
                            if (cur_en)
                            begin
                                ram_we = 1'b1;
                                if (entry.count == 32'd0)
                                begin
                                    wentry.count = entry.reload;
                                end
                                else
                                begin
                                    wentry.count = entry.count - 32'd1;
                                end
                            end
                            if (need_emit)
                            begin
                                out_load         = 1'b1;
                                beat.result_kind = RES_EXPIRED;
                                beat.expired_id  = entry.id;
                            end
                        end
                        REQ_SET:
                        begin
                            // claim the lowest free slot only
                            if (!found_reg && !cur_en)
                            begin
                                ram_we                    = 1'b1;
                                wentry.id                 = req_reg.timer_id;
                                wentry.reload             = req_reg.reload_ticks;
                                wentry.count              = req_reg.reload_ticks;
                                wentry.notify             = req_reg.notify_enable;
                                enable_next[proc_idx_reg] = 1'b1;
                                found_next                = 1'b1;
                            end
                        end
                        REQ_CLOSE:
                        begin
                            if (cur_en && (entry.id == req_reg.timer_id))
                            begin
                                enable_next[proc_idx_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!last_slot)
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = proc_idx_reg + IDX_W'(1);
                        proc_idx_next = proc_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    beat.last = 1'b1;
                    case (req_reg.req_type)
                        REQ_TICK:
                        begin
                            beat.result_kind = RES_TICK;
                            beat.system_time = tick_total_reg;
                        end
                        REQ_SET:
                        begin
                            beat.result_kind = RES_SET;
                            beat.set_ok      = found_reg;
                        end
                        default:
                        begin
                            beat.result_kind = RES_CLOSE;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            proc_idx_reg   <= '0;
            enable_reg     <= '0;
            found_reg      <= 1'b0;
            tick_total_reg <= 32'd0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_idx_reg   <= proc_idx_next;
            enable_reg     <= enable_next;
            found_reg      <= found_next;
            tick_total_reg <= tick_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    `PTS_ASSERT_SAME(a_load_when_free, clk, rst_n, out_load, out_free,
                     "result loaded into an occupied output register")
    `PTS_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, stall,
                     $stable(proc_idx_reg) && (state_reg == ST_SCAN),
                     "slot walk advanced while stalled")
    `PTS_ASSERT_NEXT(a_tick_time, clk, rst_n,
                     req_fire && (req_data.req_type == REQ_TICK),
                     tick_total_reg == $past(tick_total_reg) + 32'd1,
                     "system time did not advance on tick")
    `PTS_ASSERT_SAME(a_set_free_slot, clk, rst_n,
                     ram_we && (req_reg.req_type == REQ_SET), !cur_en && !found_reg,
                     "set wrote an enabled slot or a second slot")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic timer slot table testbench
// Runs a directed table of tick, set and close requests, then a random
// stream, with random idling on both sides. Every result beat is checked
// against an in-bench model of the slot table or the directed table's row.
// ---------------------------------------------------------------------------
module testbench;
    import pts_pkg::*;

    localparam int          NUM_SLOTS    = 8;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS = 175;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 4 * (NUM_SLOTS + 2);
    localparam int          LONG_HOLD    = 400;

    typedef struct {
        pts_in_t  beat;
        bit       typed;
        pts_out_t want;
    } plan_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    pts_in_t  req_data  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    pts_out_t rsp_data;

    // model state of the timer table
    bit          slot_on     [NUM_SLOTS];
    bit [31:0]   slot_tag    [NUM_SLOTS];
    bit [31:0]   slot_period [NUM_SLOTS];
    bit [31:0]   slot_left   [NUM_SLOTS];
    bit          slot_report [NUM_SLOTS];
    bit [31:0]   ticks_elapsed = '0;

    pts_out_t    pending_results[$];
    plan_row_t   plan[$];
    logic [31:0] id_pool [6];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          quiet_cycles   = 0;
    bit          long_hold_done = 1'b0;

    periodic_timer_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one request to the model and queue the beats it should produce.
    function automatic void step_timer_table(input pts_in_t beat);
        pts_out_t res;
        bit       claimed;
        res     = '0;
        claimed = 1'b0;
        case (beat.req_type)
            REQ_TICK:
            begin
                ticks_elapsed = ticks_elapsed + 32'd1;
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (!slot_on[s])
                        continue;
                    if (slot_left[s] == 32'd0)
                    begin
                        slot_left[s] = slot_period[s];
                        if (slot_report[s])
                        begin
                            res             = '0;
                            res.result_kind = RES_EXPIRED;
                            res.expired_id  = slot_tag[s];
                            pending_results.push_back(res);
                        end
                    end
                    else
                        slot_left[s] = slot_left[s] - 32'd1;
                end
                res             = '0;
                res.result_kind = RES_TICK;
                res.system_time = ticks_elapsed;
                res.last        = 1'b1;
                pending_results.push_back(res);
            end
            REQ_SET:
            begin
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (!claimed && !slot_on[s])
                    begin
                        slot_on[s]     = 1'b1;
                        slot_tag[s]    = beat.timer_id;
                        slot_period[s] = beat.reload_ticks;
                        slot_left[s]   = beat.reload_ticks;
                        slot_report[s] = beat.notify_enable;
                        claimed        = 1'b1;
                    end
                end
                res.result_kind = RES_SET;
                res.set_ok      = claimed;
                res.last        = 1'b1;
                pending_results.push_back(res);
            end
            REQ_CLOSE:
            begin
                // match on the stored id whether the slot is live or not
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (slot_tag[s] == beat.timer_id)
                    begin
                        slot_on[s]     = 1'b0;
                        slot_report[s] = 1'b0;
                    end
                end
                res.result_kind = RES_CLOSE;
                res.last        = 1'b1;
                pending_results.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void plan_row(input logic [1:0] req, input logic [31:0] id,
                                     input logic [31:0] reload, input logic notify,
                                     input bit typed, input logic [1:0] kind,
                                     input logic ok, input logic [31:0] stamp);
        plan_row_t row;
        row.beat.req_type      = req;
        row.beat.timer_id      = id;
        row.beat.reload_ticks  = reload;
        row.beat.notify_enable = notify;
        row.typed              = typed;
        row.want               = '0;
        row.want.result_kind   = kind;
        row.want.set_ok        = ok;
        row.want.system_time   = stamp;
        row.want.last          = 1'b1;
        plan.push_back(row);
    endfunction

    function automatic int unsigned idle_gap(input bit dense);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (dense || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic pts_in_t random_request();
        pts_in_t     r;
        int unsigned pick;
        int unsigned span;
        bit          fresh;
        pick  = $urandom_range(0, 99);
        span  = $urandom_range(0, 9);
        fresh = ($urandom_range(0, 3) == 0);
        r.timer_id      = fresh ? $urandom : id_pool[$urandom_range(0, 5)];
        r.notify_enable = ($urandom_range(0, 4) != 0);
        if (span < 6)
            r.reload_ticks = $urandom_range(0, 3);
        else if (span < 9)
            r.reload_ticks = $urandom_range(4, 20);
        else
            r.reload_ticks = $urandom;
        if (pick < 42)
            r.req_type = REQ_TICK;
        else if (pick < 70)
            r.req_type = REQ_SET;
        else if (pick < 93)
            r.req_type = REQ_CLOSE;
        else
            r.req_type = REQ_UNUSED;
        // keep some fresh ids around so later closes can hit them
        if (fresh && r.req_type == REQ_SET && $urandom_range(0, 1) == 1)
            id_pool[$urandom_range(2, 5)] = r.timer_id;
        return r;
    endfunction

    // Offer one beat, after an optional gap, and hold it until accepted.
    task automatic offer_request(input pts_in_t beat, input int unsigned gap);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    // sender
    initial
    begin
        int      held;
        int      counted;
        pts_in_t beat;

        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slot_on[s]     = 1'b0;
            slot_tag[s]    = '0;
            slot_period[s] = '0;
            slot_left[s]   = '0;
            slot_report[s] = 1'b0;
        end
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 6; k++)
            id_pool[k] = $urandom;

        plan_row(REQ_TICK,   32'h0,         32'h0,         1'b0, 1'b1, RES_TICK,  1'b0, 32'd1);
        plan_row(REQ_SET,    32'h0,         32'h0,         1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_TICK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, RES_TICK,  1'b0, 32'd0);
        plan_row(REQ_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'd5,         32'd1,         1'b0, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'hA5A5_A5A5, 32'd2,         1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'h5A5A_5A5A, 32'd3,         1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'd9,         32'd0,         1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'd9,         32'd1,         1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'h8000_0000, 32'd0,         1'b0, 1'b1, RES_SET,   1'b1, 32'd0);
        // table full
        plan_row(REQ_SET,    32'd11,        32'd0,         1'b1, 1'b1, RES_SET,   1'b0, 32'd0);
        // unused request code: no beats at all
        plan_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, RES_SET,   1'b0, 32'd0);
        plan_row(REQ_TICK,   32'h0,         32'h0,         1'b0, 1'b0, RES_TICK,  1'b0, 32'd0);
        plan_row(REQ_TICK,   32'h0,         32'h0,         1'b0, 1'b0, RES_TICK,  1'b0, 32'd0);
        plan_row(REQ_CLOSE,  32'h1234_5678, 32'h0,         1'b0, 1'b1, RES_CLOSE, 1'b0, 32'd0);
        plan_row(REQ_CLOSE,  32'd9,         32'h0,         1'b0, 1'b1, RES_CLOSE, 1'b0, 32'd0);
        plan_row(REQ_CLOSE,  32'h0,         32'h0,         1'b0, 1'b1, RES_CLOSE, 1'b0, 32'd0);
        plan_row(REQ_TICK,   32'h0,         32'h0,         1'b0, 1'b0, RES_TICK,  1'b0, 32'd0);
        plan_row(REQ_SET,    32'd77,        32'd0,         1'b1, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_SET,    32'd78,        32'hFFFF_FFFF, 1'b0, 1'b1, RES_SET,   1'b1, 32'd0);
        plan_row(REQ_TICK,   32'h0,         32'h0,         1'b0, 1'b0, RES_TICK,  1'b0, 32'd0);
        plan_row(REQ_CLOSE,  32'hFFFF_FFFF, 32'h0,         1'b0, 1'b1, RES_CLOSE, 1'b0, 32'd0);
        plan_row(REQ_CLOSE,  32'd5,         32'h0,         1'b0, 1'b1, RES_CLOSE, 1'b0, 32'd0);
        plan_row(REQ_TICK,   32'h0,         32'h0,         1'b0, 1'b0, RES_TICK,  1'b0, 32'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            offer_request(plan[i].beat, idle_gap(1'b0));
            held = pending_results.size();
            step_timer_table(plan[i].beat);
            if (plan[i].typed)
            begin
                while (pending_results.size() > held)
                    void'(pending_results.pop_back());
                pending_results.push_back(plan[i].want);
            end
        end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            beat = random_request();
            // alternate back-to-back bursts with gappy stretches
            offer_request(beat, idle_gap((counted / 25) % 3 == 0));
            step_timer_table(beat);
            if (beat.req_type != REQ_UNUSED)
                counted++;
            if (counted == RANDOM_ITEMS / 2 && beat.req_type != REQ_UNUSED)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: random ready with one long hold once traffic is flowing
    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        do
        begin
            @(posedge clk);
        end
        while (!rst_n);
        forever
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 20);
            rsp_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = $urandom_range(0, 99);
            if (stall_len < 70)
                stall_len = $urandom_range(1, 2);
            else if (stall_len < 92)
                stall_len = $urandom_range(3, 6);
            else
                stall_len = $urandom_range(10, 40);
            if (!long_hold_done && results_seen >= 80)
            begin
                stall_len      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    // check each result beat against the oldest queued expectation
    always @(posedge clk)
    begin
        pts_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: result_kind %0d", rsp_data.result_kind);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_data.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, rsp_data.result_kind);
                    mismatch_count++;
                end
                if (rsp_data.expired_id !== want.expired_id)
                begin
                    $error("expired_id: expected %0h, got %0h",
                           want.expired_id, rsp_data.expired_id);
                    mismatch_count++;
                end
                if (rsp_data.set_ok !== want.set_ok)
                begin
                    $error("set_ok: expected %0d, got %0d", want.set_ok, rsp_data.set_ok);
                    mismatch_count++;
                end
                if (rsp_data.system_time !== want.system_time)
                begin
                    $error("system_time: expected %0d, got %0d",
                           want.system_time, rsp_data.system_time);
                    mismatch_count++;
                end
                if (rsp_data.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: give up when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
